[hw/rtl/pat_pkg.sv]
package pat_pkg;

	// Default table depths
	localparam int PEND_DEPTH_DEF = 32;
	localparam int RECV_DEPTH_DEF = 64;

	// Results buffered per ack and its index width
	localparam int MAX_RESULTS = 32;
	localparam int ABW = $clog2(MAX_RESULTS);
	localparam int NAW = $clog2(MAX_RESULTS + 1);

	// Window prune span and RTT arithmetic
	localparam logic [31:0] WINDOW_SPAN = 32'd34;
	localparam logic [31:0] BIT_SPAN = 32'd31;
	localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

	// Configuration registers
	localparam int CFG_IW = 1;
	localparam logic [CFG_IW-1:0] REG_MAX_SEQ = 1'd0;
	localparam logic [CFG_IW-1:0] REG_RTT_MAX = 1'd1;

	// Operation codes
	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_RECV = 2'd1;
	localparam logic [1:0] OP_ACK = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_SEND,
		CMD_RSCAN_EV,
		CMD_RINSERT,
		CMD_ACK_KEEP,
		CMD_ACK_HIT,
		CMD_RTT_MUL,
		CMD_RTT_DIV,
		CMD_ACK_END,
		CMD_AGE_WR,
		CMD_LATEST_RD,
		CMD_LO,
		CMD_PRUNE_RD,
		CMD_PRUNE_DROP,
		CMD_EXP_RD,
		CMD_EXP_DROP,
		CMD_HDR_INIT,
		CMD_HDR_EV,
		CMD_EM_LOAD
	} pat_cmd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_SEND,
		S_RS_RD,
		S_RS_EV,
		S_R_INS,
		S_AK_RD,
		S_AK_EV,
		S_RTT_MUL,
		S_RTT_DIV,
		S_AK_END,
		S_AG_RD,
		S_AG_WR,
		S_LT_RD,
		S_LT_LO,
		S_PR_RD,
		S_PR_EV,
		S_EX_RD,
		S_EX_EV,
		S_HDR_INIT,
		S_HD_RD,
		S_HD_EV,
		S_EM_RD,
		S_EM_LD,
		S_EM_WAIT
	} pat_state_t;

	typedef struct packed {
		logic [1:0] op;
		logic       p_end;
		logic       r_end;
		logic       p_empty;
		logic       r_empty;
		logic       ack_hit;
		logic       prune_drop;
		logic       exp_drop;
		logic       hdr_stop;
		logic       out_fire;
		logic       out_last;
	} pat_status_t;

endpackage

[hw/rtl/pat_ctrl.sv]
module pat_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output pat_pkg::pat_cmd_t  cmd,
	input  pat_pkg::pat_status_t st
);
	import pat_pkg::*;

	pat_state_t state_q, state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				unique case (st.op)
					OP_SEND: state_d = S_SEND;
					OP_RECV: state_d = S_RS_RD;
					OP_ACK:  state_d = S_AK_RD;
					OP_TICK: state_d = S_AG_RD;
				endcase
			end
			S_SEND:     state_d = S_HDR_INIT;
			S_RS_RD:    state_d = st.r_end ? S_R_INS : S_RS_EV;
			S_RS_EV:    state_d = S_RS_RD;
			S_R_INS:    state_d = S_HDR_INIT;
			S_AK_RD:    state_d = st.p_end ? S_AK_END : S_AK_EV;
			S_AK_EV:    state_d = st.ack_hit ? S_RTT_MUL : S_AK_RD;
			S_RTT_MUL:  state_d = S_RTT_DIV;
			S_RTT_DIV:  state_d = S_AK_RD;
			S_AK_END:   state_d = S_HDR_INIT;
			S_AG_RD:    state_d = st.p_end ? S_LT_RD : S_AG_WR;
			S_AG_WR:    state_d = S_AG_RD;
			S_LT_RD:    state_d = st.r_empty ? S_EX_RD : S_LT_LO;
			S_LT_LO:    state_d = S_PR_RD;
			S_PR_RD:    state_d = st.r_empty ? S_EX_RD : S_PR_EV;
			S_PR_EV:    state_d = st.prune_drop ? S_PR_RD : S_EX_RD;
			S_EX_RD:    state_d = st.p_empty ? S_HDR_INIT : S_EX_EV;
			S_EX_EV:    state_d = st.exp_drop ? S_EX_RD : S_HDR_INIT;
			S_HDR_INIT: state_d = S_HD_RD;
			S_HD_RD:    state_d = st.r_end ? S_EM_RD : S_HD_EV;
			S_HD_EV:    state_d = st.hdr_stop ? S_EM_RD : S_HD_RD;
			S_EM_RD:    state_d = S_EM_LD;
			S_EM_LD:    state_d = S_EM_WAIT;
			S_EM_WAIT: begin
				if (st.out_fire) state_d = st.out_last ? S_IDLE : S_EM_RD;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// Issue datapath commands
	always_comb begin
		cmd = CMD_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd = CMD_CAPTURE;
			end
			S_SEND:     cmd = CMD_SEND;
			S_RS_EV:    cmd = CMD_RSCAN_EV;
			S_R_INS:    cmd = CMD_RINSERT;
			S_AK_EV:    cmd = st.ack_hit ? CMD_ACK_HIT : CMD_ACK_KEEP;
			S_RTT_MUL:  cmd = CMD_RTT_MUL;
			S_RTT_DIV:  cmd = CMD_RTT_DIV;
			S_AK_END:   cmd = CMD_ACK_END;
			S_AG_WR:    cmd = CMD_AGE_WR;
			S_LT_RD:    cmd = CMD_LATEST_RD;
			S_LT_LO:    cmd = CMD_LO;
			S_PR_RD:    cmd = CMD_PRUNE_RD;
			S_PR_EV:    cmd = st.prune_drop ? CMD_PRUNE_DROP : CMD_NONE;
			S_EX_RD:    cmd = CMD_EXP_RD;
			S_EX_EV:    cmd = st.exp_drop ? CMD_EXP_DROP : CMD_NONE;
			S_HDR_INIT: cmd = CMD_HDR_INIT;
			S_HD_EV:    cmd = st.hdr_stop ? CMD_NONE : CMD_HDR_EV;
			S_EM_LD:    cmd = CMD_EM_LOAD;
			default:    cmd = CMD_NONE;
		endcase
	end

endmodule

[hw/rtl/pat_dp.sv]
module pat_dp #(
	parameter int PEND_DEPTH = pat_pkg::PEND_DEPTH_DEF,
	parameter int RECV_DEPTH = pat_pkg::RECV_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pat_pkg::pat_cmd_t           cmd,
	output pat_pkg::pat_status_t        st,
	input  logic                        cfg_wr_en,
	input  logic [pat_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic [1:0]                  op,
	input  logic [31:0]                 sequence_req,
	input  logic [31:0]                 ack_sequence,
	input  logic [31:0]                 ack_mask,
	input  logic [15:0]                 elapsed_ms,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        acked_valid,
	output logic [31:0]                 acked_seq_out,
	output logic                        last_of_run,
	output logic [31:0]                 assigned_sequence,
	output logic [31:0]                 ack_for_header,
	output logic [31:0]                 ack_bits_for_header,
	output logic [23:0]                 rtt_out,
	output logic [31:0]                 lost_total,
	output logic [31:0]                 sent_total,
	output logic [31:0]                 recv_total,
	output logic [31:0]                 acked_total
);
	import pat_pkg::*;

	localparam int PAW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
	localparam int PCW = $clog2(PEND_DEPTH + 1);
	localparam int RAW = $clog2(RECV_DEPTH);
	localparam int RCW = $clog2(RECV_DEPTH + 1);
	localparam int IW = (PCW > RCW) ? PCW : RCW;

	// Configuration and input word
	logic [31:0] max_seq_q;
	logic [15:0] rtt_max_q;
	logic [1:0]  op_q;
	logic [31:0] seq_in_q, ack_q, abits_q;
	logic [15:0] elapsed_q;

	// Link state
	logic [31:0] next_local_q, remote_q, assigned_q, hbits_q, lo_q;
	logic [23:0] rtt_q;
	logic [31:0] lost_q, sent_q, recv_q, acked_q;
	logic        dup_q;
	logic [28:0] t_q;
	logic [60:0] prod_q;
	logic [IW-1:0]  idx_q;
	logic [PCW-1:0] w_q;
	logic [NAW-1:0] nacked_q, em_idx_q;
	logic        out_valid_q, out_last_q;
	logic [31:0] out_seq_q;
	logic [PAW-1:0] p_head_q;
	logic [PCW-1:0] p_cnt_q;
	logic [RAW-1:0] r_head_q;
	logic [RCW-1:0] r_cnt_q;

	// Tables
	logic [31:0] pend_seq_mem [PEND_DEPTH];
	logic [15:0] pend_age_mem [PEND_DEPTH];
	logic [31:0] recv_mem [RECV_DEPTH];
	logic [31:0] abuf_mem [MAX_RESULTS];
	logic [31:0] pend_seq_rd_q, recv_rd_q, abuf_rd_q;
	logic [15:0] pend_age_rd_q;

	function automatic logic [PAW-1:0] p_phys(input logic [PAW-1:0] h, input logic [PCW-1:0] l);
		logic [PCW:0] s;
		s = (PCW+1)'(h) + (PCW+1)'(l);
		if (s >= (PCW+1)'(PEND_DEPTH)) s = s - (PCW+1)'(PEND_DEPTH);
		return s[PAW-1:0];
	endfunction

	function automatic logic [RAW-1:0] r_phys(input logic [RAW-1:0] h, input logic [RCW-1:0] l);
		logic [RCW:0] s;
		s = (RCW+1)'(h) + (RCW+1)'(l);
		if (s >= (RCW+1)'(RECV_DEPTH)) s = s - (RCW+1)'(RECV_DEPTH);
		return s[RAW-1:0];
	endfunction

	function automatic logic [PAW-1:0] p_inc(input logic [PAW-1:0] h);
		return (h == PAW'(PEND_DEPTH - 1)) ? '0 : h + 1'b1;
	endfunction

	function automatic logic [RAW-1:0] r_inc(input logic [RAW-1:0] h);
		return (h == RAW'(RECV_DEPTH - 1)) ? '0 : h + 1'b1;
	endfunction

	// a is more recent than b under wrap at m
	function automatic logic newer(input logic [31:0] a, input logic [31:0] b,
	                               input logic [31:0] m);
		logic [31:0] half;
		half = m >> 1;
		if (a > b) return (a - b) <= half;
		if (b > a) return (b - a) > half;
		return 1'b0;
	endfunction

	function automatic logic [31:0] bit_pos(input logic [31:0] s, input logic [31:0] a,
	                                        input logic [31:0] m);
		if (s > a) return a + (m - s);
		return a - 32'd1 - s;
	endfunction

	// Table addressing
	logic [PCW-1:0] pr_log;
	logic [PAW-1:0] pr_addr, pw_addr;
	logic           pw_seq_en, pw_age_en;
	logic [31:0]    pw_seq;
	logic [15:0]    pw_age;
	logic [RCW-1:0] rr_log;
	logic [RAW-1:0] rr_addr, rw_addr;
	logic           rw_en;
	logic [16:0]    age_sum;
	logic           p_full, r_full;

	assign p_full = p_cnt_q == PCW'(PEND_DEPTH);
	assign r_full = r_cnt_q == RCW'(RECV_DEPTH);
	assign age_sum = {1'b0, pend_age_rd_q} + {1'b0, elapsed_q};
	assign pr_log = (cmd == CMD_EXP_RD) ? '0 : PCW'(idx_q);
	assign pr_addr = p_phys(p_head_q, pr_log);
	assign rr_addr = r_phys(r_head_q, rr_log);
	assign rw_addr = r_phys(r_head_q, r_cnt_q);
	assign rw_en = (cmd == CMD_RINSERT) && !dup_q;

	always_comb begin
		unique case (cmd)
			CMD_LATEST_RD: rr_log = (r_cnt_q == '0) ? '0 : r_cnt_q - 1'b1;
			CMD_PRUNE_RD:  rr_log = '0;
			default:       rr_log = RCW'(idx_q);
		endcase
	end

	// Select pending table write
	always_comb begin
		pw_seq_en = 1'b0;
		pw_age_en = 1'b0;
		pw_addr = p_phys(p_head_q, PCW'(idx_q));
		pw_seq = pend_seq_rd_q;
		pw_age = pend_age_rd_q;
		unique case (cmd)
			CMD_SEND: begin
				pw_seq_en = 1'b1;
				pw_age_en = 1'b1;
				pw_addr = p_phys(p_head_q, p_cnt_q);
				pw_seq = next_local_q;
				pw_age = '0;
			end
			CMD_ACK_KEEP: begin
				pw_seq_en = 1'b1;
				pw_age_en = 1'b1;
				pw_addr = p_phys(p_head_q, w_q);
			end
			CMD_AGE_WR: begin
				pw_age_en = 1'b1;
				pw_age = age_sum[16] ? 16'hFFFF : age_sum[15:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pw_seq_en) pend_seq_mem[pw_addr] <= pw_seq;
		if (pw_age_en) pend_age_mem[pw_addr] <= pw_age;
		pend_seq_rd_q <= pend_seq_mem[pr_addr];
		pend_age_rd_q <= pend_age_mem[pr_addr];
	end

	always_ff @(posedge clk) begin
		if (rw_en) recv_mem[rw_addr] <= seq_in_q;
		recv_rd_q <= recv_mem[rr_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_ACK_HIT) abuf_mem[nacked_q[ABW-1:0]] <= pend_seq_rd_q;
		abuf_rd_q <= abuf_mem[em_idx_q[ABW-1:0]];
	end

	// Ack coverage of the entry just read
	logic [31:0] ack_bp, hdr_bp;
	logic        ack_cover;
	assign ack_bp = bit_pos(pend_seq_rd_q, ack_q, max_seq_q);
	assign ack_cover = (pend_seq_rd_q == ack_q) ||
		(!newer(pend_seq_rd_q, ack_q, max_seq_q) && (ack_bp <= BIT_SPAN) &&
		 abits_q[ack_bp[4:0]]);
	assign hdr_bp = bit_pos(recv_rd_q, remote_q, max_seq_q);

	// RTT numerator: 9*rtt + age*256 + 5
	logic [28:0] t_next;
	assign t_next = ({5'd0, rtt_q} << 3) + {5'd0, rtt_q} + {5'd0, pend_age_rd_q, 8'd0} + 29'd5;

	logic [31:0] lo_next;
	assign lo_next = (recv_rd_q >= WINDOW_SPAN) ? recv_rd_q - WINDOW_SPAN
	                                            : max_seq_q - (WINDOW_SPAN - recv_rd_q);

	logic out_fire;
	assign out_fire = out_valid_q && out_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seq_q <= 32'hFFFFFFFF;
			rtt_max_q <= 16'd1000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAX_SEQ: max_seq_q <= cfg_data;
				REG_RTT_MAX: rtt_max_q <= cfg_data[15:0];
			endcase
		end
	end

	// Execute commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_local_q <= '0;
			remote_q <= '0;
			rtt_q <= '0;
			lost_q <= '0;
			sent_q <= '0;
			recv_q <= '0;
			acked_q <= '0;
			p_head_q <= '0;
			p_cnt_q <= '0;
			r_head_q <= '0;
			r_cnt_q <= '0;
			idx_q <= '0;
			w_q <= '0;
			nacked_q <= '0;
			em_idx_q <= '0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
			dup_q <= 1'b0;
			op_q <= OP_SEND;
			assigned_q <= '0;
			hbits_q <= '0;
		end else begin
			unique case (cmd)
				CMD_CAPTURE: begin
					op_q <= op;
					seq_in_q <= sequence_req;
					ack_q <= ack_sequence;
					abits_q <= ack_mask;
					elapsed_q <= elapsed_ms;
					idx_q <= '0;
					w_q <= '0;
					nacked_q <= '0;
					em_idx_q <= '0;
					dup_q <= 1'b0;
					assigned_q <= '0;
				end
				CMD_SEND: begin
					assigned_q <= next_local_q;
					sent_q <= sent_q + 32'd1;
					if (p_full) begin
						p_head_q <= p_inc(p_head_q);
						lost_q <= lost_q + 32'd1;
					end else begin
						p_cnt_q <= p_cnt_q + 1'b1;
					end
					if ({1'b0, next_local_q} + 33'd1 > {1'b0, max_seq_q}) next_local_q <= '0;
					else next_local_q <= next_local_q + 32'd1;
				end
				CMD_RSCAN_EV: begin
					if (recv_rd_q == seq_in_q) dup_q <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				CMD_RINSERT: begin
					recv_q <= recv_q + 32'd1;
					if (!dup_q) begin
						if (r_full) r_head_q <= r_inc(r_head_q);
						else r_cnt_q <= r_cnt_q + 1'b1;
						if (newer(seq_in_q, remote_q, max_seq_q)) remote_q <= seq_in_q;
					end
				end
				CMD_ACK_KEEP: begin
					w_q <= w_q + 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				CMD_ACK_HIT: begin
					nacked_q <= nacked_q + 1'b1;
					acked_q <= acked_q + 32'd1;
					idx_q <= idx_q + 1'b1;
					t_q <= t_next;
				end
				CMD_RTT_MUL:    prod_q <= 61'(t_q) * 61'(RECIP_TEN);
				CMD_RTT_DIV:    rtt_q <= prod_q[58:35];
				CMD_ACK_END:    p_cnt_q <= w_q;
				CMD_AGE_WR:     idx_q <= idx_q + 1'b1;
				CMD_LO:         lo_q <= lo_next;
				CMD_PRUNE_DROP: begin
					r_head_q <= r_inc(r_head_q);
					r_cnt_q <= r_cnt_q - 1'b1;
				end
				CMD_EXP_DROP: begin
					p_head_q <= p_inc(p_head_q);
					p_cnt_q <= p_cnt_q - 1'b1;
					lost_q <= lost_q + 32'd1;
				end
				CMD_HDR_INIT: begin
					idx_q <= '0;
					hbits_q <= '0;
				end
				CMD_HDR_EV: begin
					if (hdr_bp <= BIT_SPAN) hbits_q[hdr_bp[4:0]] <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				CMD_EM_LOAD: begin
					out_valid_q <= 1'b1;
					out_seq_q <= (nacked_q != '0) ? abuf_rd_q : '0;
					out_last_q <= (nacked_q == '0) || (em_idx_q == nacked_q - 1'b1);
				end
				default: ;
			endcase
			// Drop the word once taken
			if (out_fire) begin
				out_valid_q <= 1'b0;
				em_idx_q <= em_idx_q + 1'b1;
			end
		end
	end

	// Status to the controller
	always_comb begin
		st.op = op_q;
		st.p_end = idx_q == IW'(p_cnt_q);
		st.r_end = idx_q == IW'(r_cnt_q);
		st.p_empty = p_cnt_q == '0;
		st.r_empty = r_cnt_q == '0;
		st.ack_hit = ack_cover && (nacked_q != NAW'(MAX_RESULTS));
		st.prune_drop = !newer(recv_rd_q, lo_q, max_seq_q);
		st.exp_drop = {1'b0, pend_age_rd_q} > ({1'b0, rtt_max_q} + 17'd1);
		st.hdr_stop = (recv_rd_q == remote_q) || newer(recv_rd_q, remote_q, max_seq_q);
		st.out_fire = out_fire;
		st.out_last = out_last_q;
	end

	assign out_valid = out_valid_q;
	assign acked_valid = nacked_q != '0;
	assign acked_seq_out = out_seq_q;
	assign last_of_run = out_last_q;
	assign assigned_sequence = assigned_q;
	assign ack_for_header = remote_q;
	assign ack_bits_for_header = hbits_q;
	assign rtt_out = rtt_q;
	assign lost_total = lost_q;
	assign sent_total = sent_q;
	assign recv_total = recv_q;
	assign acked_total = acked_q;

endmodule

[hw/rtl/packet_ack_tracker.sv]
// Channel   Handshake               Word
// in        in_valid / in_ready     op, sequence_req, payload_size, ack_sequence,
//                                   ack_mask, elapsed_ms
// out       out_valid / out_ready   acked_valid .. acked_total, last_of_run ends a run
// cfg       cfg_wr_en               cfg_index, cfg_data (no wait)
//
// One word is worked at a time; the next is taken after the last result leaves.
// Each word is dispatched on its op. A send writes one pending entry; a receive scans
// the window and then inserts; an ack walks the pending entries, keeping or retiring
// each; a tick ages every pending entry, then prunes the window and expires pending
// entries. A header walk over the window and the results follow. The pending and
// window memories are read one entry per step. Reset clears counters and table counts;
// out_ready low holds the current result.
module packet_ack_tracker #(
	parameter int PEND_DEPTH = pat_pkg::PEND_DEPTH_DEF,
	parameter int RECV_DEPTH = pat_pkg::RECV_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 op,
	input  logic [31:0]                sequence_req,
	input  logic [15:0]                payload_size,
	input  logic [31:0]                ack_sequence,
	input  logic [31:0]                ack_mask,
	input  logic [15:0]                elapsed_ms,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       acked_valid,
	output logic [31:0]                acked_seq_out,
	output logic                       last_of_run,
	output logic [31:0]                assigned_sequence,
	output logic [31:0]                ack_for_header,
	output logic [31:0]                ack_bits_for_header,
	output logic [23:0]                rtt_out,
	output logic [31:0]                lost_total,
	output logic [31:0]                sent_total,
	output logic [31:0]                recv_total,
	output logic [31:0]                acked_total,
	input  logic                       cfg_wr_en,
	input  logic [pat_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]                cfg_data
);
	import pat_pkg::*;

	pat_cmd_t    cmd;
	pat_status_t st;

	pat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.st       (st)
	);

	pat_dp #(
		.PEND_DEPTH (PEND_DEPTH),
		.RECV_DEPTH (RECV_DEPTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.st                  (st),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.op                  (op),
		.sequence_req        (sequence_req),
		.ack_sequence        (ack_sequence),
		.ack_mask            (ack_mask),
		.elapsed_ms          (elapsed_ms),
		.out_ready           (out_ready),
		.out_valid           (out_valid),
		.acked_valid         (acked_valid),
		.acked_seq_out       (acked_seq_out),
		.last_of_run         (last_of_run),
		.assigned_sequence   (assigned_sequence),
		.ack_for_header      (ack_for_header),
		.ack_bits_for_header (ack_bits_for_header),
		.rtt_out             (rtt_out),
		.lost_total          (lost_total),
		.sent_total          (sent_total),
		.recv_total          (recv_total),
		.acked_total         (acked_total)
	);

	// Never take a new word while a result is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	// A run continues after a result that is not the last
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> !in_ready)
		else $error("run ended early");

	// A result without an acked sequence stands alone
	a_single_plain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !acked_valid |-> last_of_run)
		else $error("plain result not last");

endmodule
